>>> design/led_sequence_player_core_defines.svh
// assertion macros for the led sequence player
`ifndef LED_SEQUENCE_PLAYER_CORE_DEFINES_SVH
`define LED_SEQUENCE_PLAYER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("led sequence player check failed");

// next-cycle implication, disabled in reset
`define LSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("led sequence player check failed");

`endif

>>> design/lsp_pkg.sv
// shared types and constants for the led sequence player
`default_nettype none

package lsp_pkg;

  localparam int SLOT_COUNT_DEF = 5;
  localparam int LED_COUNT      = 3;

  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int MASK_W  = 3;
  localparam int PER_W   = 16;
  localparam int DUR_W   = 24;
  localparam int CNT_W   = 3;
  localparam int STEP_W  = 3;
  localparam int HALF_W  = 10;

  localparam logic [DUR_W-1:0]  DUR_MAX        = '1;
  localparam logic [HALF_W-1:0] IDLE_HALF_RST  = HALF_W'(100);
  localparam logic [HALF_W-1:0] RUN_HALF_RST   = HALF_W'(500);

  // user leds that exist on the board
  localparam logic [MASK_W-1:0] LED_EN_MASK =
    (LED_COUNT >= MASK_W) ? '1 : MASK_W'((1 << LED_COUNT) - 1);

  localparam logic [0:0] CFG_IDLE_HALF = 1'b0;
  localparam logic [0:0] CFG_RUN_HALF  = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_BUTTON = 3'd4
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] mask;
    logic [PER_W-1:0]  period;
    logic [DUR_W-1:0]  dur;
  } tbl_wr_t;

  typedef struct packed {
    logic  fire;
    logic  tick;
    mode_t mode_cur;
    mode_t mode_nxt;
  } mode_evt_t;

endpackage

`default_nettype wire

>>> design/led_sequence_player_core.sv
// led sequence player top level: input register, update logic, result register
//
//   channel | dir | handshake          | word
//   in_     | in  | in_valid/in_stall  | command, slot, mask, period, duration, count
//   out_    | out | out_valid/out_stall| user leds, status led, run mode, step number
//   cfg_    | in  | cfg_valid/cfg_ready| register index, 10-bit half time
//
// one word per cycle while out_stall is low; a word accepted into the input register
// moves on to the result register once that register is free or being emptied.
// the throughput is set by the single pass through the sequencer next-state logic.
// synchronous active-low reset clears control state; the step table is not cleared.
// in_stall rises only while a finished result is held by out_stall.
// cfg_ready is always high.
`default_nettype none

module led_sequence_player_core import lsp_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [SLOT_W-1:0] in_step_slot,
  input  wire logic [MASK_W-1:0] in_lamp_mask,
  input  wire logic [PER_W-1:0]  in_period_ms,
  input  wire logic [DUR_W-1:0]  in_min_len_ms,
  input  wire logic [CNT_W-1:0]  in_play_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [MASK_W-1:0] out_user_leds,
  output logic                   out_status_led,
  output logic      [1:0]        out_run_mode,
  output logic      [STEP_W-1:0] out_step_number,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [HALF_W-1:0] cfg_wdata
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int POS_W = $clog2(SLOT_COUNT + 1);

  logic              s1_vld_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [MASK_W-1:0] s1_mask_r;
  logic [PER_W-1:0]  s1_per_r;
  logic [DUR_W-1:0]  s1_dur_r;
  logic [CNT_W-1:0]  s1_cnt_r;
  logic              adv, fire, in_take;

  logic [IDX_W-1:0]  rd_idx, mask_idx;
  logic [PER_W-1:0]  rd_period;
  logic [DUR_W-1:0]  rd_dur;
  logic [MASK_W-1:0] rd_mask, leds_nxt;
  logic [STEP_W-1:0] step_nxt;
  logic              status_led_nxt;
  tbl_wr_t           wr;
  mode_evt_t         evt;

  // result register free or being emptied
  assign adv      = !out_valid || !out_stall;
  assign fire     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv || !s1_vld_r) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_command;
      s1_slot_r <= in_step_slot;
      s1_mask_r <= in_lamp_mask;
      s1_per_r  <= in_period_ms;
      s1_dur_r  <= in_min_len_ms;
      s1_cnt_r  <= in_play_count;
    end
  end

  lsp_seq #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W), .POS_W(POS_W)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .command    (s1_cmd_r),
    .step_slot  (s1_slot_r),
    .lamp_mask  (s1_mask_r),
    .period_ms  (s1_per_r),
    .min_len_ms (s1_dur_r),
    .play_count (s1_cnt_r),
    .rd_period  (rd_period),
    .rd_dur     (rd_dur),
    .rd_mask    (rd_mask),
    .rd_idx     (rd_idx),
    .mask_idx   (mask_idx),
    .wr         (wr),
    .evt        (evt),
    .leds_nxt   (leds_nxt),
    .step_nxt   (step_nxt)
  );

  lsp_table #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W)) u_table (
    .clk      (clk),
    .wr       (wr),
    .rd_idx   (rd_idx),
    .mask_idx (mask_idx),
    .rd_period(rd_period),
    .rd_dur   (rd_dur),
    .rd_mask  (rd_mask)
  );

  lsp_status u_status (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .evt           (evt),
    .status_led_nxt(status_led_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_user_leds   <= leds_nxt;
      out_status_led  <= status_led_nxt;
      out_run_mode    <= evt.mode_nxt;
      out_step_number <= step_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/lsp_table.sv
// step table: mask, period and duration per slot
`default_nettype none

module lsp_table import lsp_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic              clk,
  input  wire tbl_wr_t           wr,
  input  wire logic [IDX_W-1:0]  rd_idx,
  input  wire logic [IDX_W-1:0]  mask_idx,
  output logic      [PER_W-1:0]  rd_period,
  output logic      [DUR_W-1:0]  rd_dur,
  output logic      [MASK_W-1:0] rd_mask
);

  logic [MASK_W-1:0] masks_r   [SLOT_COUNT];
  logic [PER_W-1:0]  periods_r [SLOT_COUNT];
  logic [DUR_W-1:0]  durs_r    [SLOT_COUNT];
  logic [IDX_W-1:0]  wr_idx;

  assign wr_idx = IDX_W'(wr.slot);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      masks_r[wr_idx]   <= wr.mask;
      periods_r[wr_idx] <= wr.period;
      durs_r[wr_idx]    <= wr.dur;
    end
  end

  assign rd_period = periods_r[rd_idx];
  assign rd_dur    = durs_r[rd_idx];

  // a write in the same item is already visible in its result
  always_comb begin
    if (wr.en && wr_idx == mask_idx) begin
      rd_mask = wr.mask;
    end else begin
      rd_mask = masks_r[mask_idx];
    end
  end

endmodule

`default_nettype wire

>>> design/lsp_status.sv
// status led blink timer and its half-time registers
`default_nettype none

module lsp_status import lsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [HALF_W-1:0] cfg_wdata,
  input  wire mode_evt_t         evt,
  output logic                   status_led_nxt
);

  logic [HALF_W-1:0] idle_half_r, run_half_r;
  logic [HALF_W-1:0] stat_time_r, stat_time_nxt, stat_time_inc, half;
  logic              stat_on_r, stat_on_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_half_r <= IDLE_HALF_RST;
      run_half_r  <= RUN_HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDLE_HALF: idle_half_r <= cfg_wdata;
        CFG_RUN_HALF:  run_half_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    half = (evt.mode_cur == MODE_RUN) ? run_half_r : idle_half_r;
    if (half == '0) begin
      half = HALF_W'(1);
    end
    stat_time_inc = stat_time_r + HALF_W'(1);
    stat_time_nxt = stat_time_r;
    stat_on_nxt   = stat_on_r;
    if (evt.fire) begin
      if (evt.tick && evt.mode_cur != MODE_PAUSE) begin
        if (stat_time_inc >= half) begin
          stat_time_nxt = '0;
          stat_on_nxt   = ~stat_on_r;
        end else begin
          stat_time_nxt = stat_time_inc;
        end
      end
      // every mode starts its pattern lit
      if (evt.mode_nxt != evt.mode_cur) begin
        stat_time_nxt = '0;
        stat_on_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_time_r <= '0;
      stat_on_r   <= 1'b1;
    end else begin
      stat_time_r <= stat_time_nxt;
      stat_on_r   <= stat_on_nxt;
    end
  end

  assign status_led_nxt = (evt.mode_nxt == MODE_PAUSE) ? 1'b1 : stat_on_nxt;

endmodule

`default_nettype wire

>>> design/lsp_seq.sv
// sequencer: run mode, step position and step timing
`default_nettype none

module lsp_seq import lsp_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  parameter int POS_W      = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [SLOT_W-1:0] step_slot,
  input  wire logic [MASK_W-1:0] lamp_mask,
  input  wire logic [PER_W-1:0]  period_ms,
  input  wire logic [DUR_W-1:0]  min_len_ms,
  input  wire logic [CNT_W-1:0]  play_count,
  input  wire logic [PER_W-1:0]  rd_period,
  input  wire logic [DUR_W-1:0]  rd_dur,
  input  wire logic [MASK_W-1:0] rd_mask,
  output logic      [IDX_W-1:0]  rd_idx,
  output logic      [IDX_W-1:0]  mask_idx,
  output tbl_wr_t                wr,
  output mode_evt_t              evt,
  output logic      [MASK_W-1:0] leds_nxt,
  output logic      [STEP_W-1:0] step_nxt
);

  mode_t              mode_r, mode_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt, pos_inc, loaded_r, loaded_nxt;
  logic               pend_r, pend_nxt;
  logic [DUR_W-1:0]   st_r, st_nxt, st_inc;
  logic [PER_W-1:0]   ht_r, ht_nxt, ht_inc, half;
  logic               blink_r, blink_nxt;
  logic               step_end;
  cmd_t               cmd;

  function automatic logic [IDX_W-1:0] to_idx(input logic [POS_W-1:0] p);
    return (32'(p) < SLOT_COUNT) ? IDX_W'(p) : '0;
  endfunction

  assign cmd     = cmd_t'(command);
  assign rd_idx  = to_idx(pos_r);
  assign pos_inc = pos_r + POS_W'(1);
  assign st_inc  = (st_r < DUR_MAX) ? st_r + DUR_W'(1) : st_r;
  assign ht_inc  = ht_r + PER_W'(1);

  always_comb begin
    half = rd_period >> 1;
    if (half == '0) begin
      half = PER_W'(1);
    end
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    loaded_nxt = loaded_r;
    pend_nxt   = pend_r;
    st_nxt     = st_r;
    ht_nxt     = ht_r;
    blink_nxt  = blink_r;
    step_end   = 1'b0;
    if (fire) begin
      case (cmd)
        CMD_TICK: begin
          if (mode_r == MODE_RUN) begin
            st_nxt = st_inc;
            if (rd_period == '0) begin
              blink_nxt = 1'b1;
              step_end  = (st_inc >= rd_dur);
            end else if (ht_inc >= half) begin
              ht_nxt = '0;
              if (st_inc >= rd_dur) begin
                step_end = 1'b1;
              end else begin
                blink_nxt = ~blink_r;
              end
            end else begin
              ht_nxt = ht_inc;
            end
            if (step_end) begin
              pos_nxt = pos_inc;
              if (pos_inc >= loaded_r) begin
                mode_nxt = MODE_IDLE;
                pend_nxt = 1'b0;
              end else if (pend_r) begin
                mode_nxt = MODE_PAUSE;
                pend_nxt = 1'b0;
              end else begin
                st_nxt    = '0;
                ht_nxt    = '0;
                blink_nxt = 1'b1;
              end
            end
          end
        end
        CMD_START: begin
          if (play_count != '0) begin
            loaded_nxt = (32'(play_count) > SLOT_COUNT) ? POS_W'(SLOT_COUNT)
                                                         : POS_W'(play_count);
            pos_nxt    = '0;
            pend_nxt   = 1'b0;
            st_nxt     = '0;
            ht_nxt     = '0;
            blink_nxt  = 1'b1;
            mode_nxt   = MODE_RUN;
          end
        end
        CMD_STOP: begin
          pend_nxt = 1'b0;
          mode_nxt = MODE_IDLE;
        end
        CMD_BUTTON: begin
          if (mode_r == MODE_RUN) begin
            pend_nxt = 1'b1;
          end else if (mode_r == MODE_PAUSE) begin
            st_nxt    = '0;
            ht_nxt    = '0;
            blink_nxt = 1'b1;
            mode_nxt  = MODE_RUN;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    wr.en        = fire && (cmd == CMD_WRITE) && (32'(step_slot) < SLOT_COUNT);
    wr.slot      = step_slot;
    wr.mask      = lamp_mask;
    wr.period    = period_ms;
    wr.dur       = min_len_ms;
    evt.fire     = fire;
    evt.tick     = (cmd == CMD_TICK);
    evt.mode_cur = mode_r;
    evt.mode_nxt = mode_nxt;
    mask_idx     = to_idx(pos_nxt);
    leds_nxt     = (mode_nxt == MODE_RUN && blink_nxt) ? (rd_mask & LED_EN_MASK) : '0;
    step_nxt     = STEP_W'(pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      loaded_r <= '0;
      pend_r   <= 1'b0;
      st_r     <= '0;
      ht_r     <= '0;
      blink_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      loaded_r <= loaded_nxt;
      pend_r   <= pend_nxt;
      st_r     <= st_nxt;
      ht_r     <= ht_nxt;
      blink_r  <= blink_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/lsp_checker.sv
// port-level checks for the led sequence player, bound to the top level
`default_nettype none

`include "led_sequence_player_core_defines.svh"

module lsp_checker import lsp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [MASK_W-1:0] out_user_leds,
  input wire logic              out_status_led,
  input wire logic [1:0]        out_run_mode,
  input wire logic [STEP_W-1:0] out_step_number
);

  // leds are dark unless a sequence is running
  `LSP_ASSERT_NOW(a_leds_dark, out_valid && out_run_mode != MODE_RUN, out_user_leds == '0)

  // paused shows a steady status led
  `LSP_ASSERT_NOW(a_pause_lit, out_valid && out_run_mode == MODE_PAUSE, out_status_led)

  // input side only holds off behind a held result
  `LSP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // a held result keeps its word
  `LSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_user_leds) && $stable(out_status_led) &&
                   $stable(out_run_mode) && $stable(out_step_number))

endmodule

bind led_sequence_player_core lsp_checker u_lsp_checker (.*);

`default_nettype wire
